>>> sv/trb_pkg.sv
// Shared types and constants for the timestamp reorder buffer.
// No dependencies; the cell and the top level import this package.
package trb_pkg;

	// One held key event.
	typedef struct packed {
		logic [7:0]  position;
		logic        pressed;
		logic        own_half;
		logic [31:0] stamp;
	} trb_entry_t;

	// What every cell of the row does in this cycle.
	typedef struct packed {
		logic ins;   // sorted insert of the incoming event
		logic shl;   // shift towards the head while the row is drained
	} trb_cell_op_t;

	// Action codes of a request.
	localparam logic [1:0] ACT_KEY  = 2'd0;
	localparam logic [1:0] ACT_LINK = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// Configuration register indexes.
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_ACTIVE = 1'b1;

	localparam logic [15:0] WINDOW_RESET = 16'd2000;
	localparam logic [23:0] ACTIVE_RESET = 24'd200000;
	localparam logic [23:0] AGE_MAX      = 24'hFFFFFF;

endpackage

>>> sv/trb_cell.sv
// One cell of the sorted row of held events.
// Depends on trb_pkg for the entry and operation types.
module trb_cell
	import trb_pkg::*;
(
	input  logic         clk,
	input  trb_cell_op_t op,
	input  logic         live,
	input  trb_entry_t   new_ent,
	input  trb_entry_t   left_ent,
	input  logic         left_gt,
	input  trb_entry_t   right_ent,
	output trb_entry_t   ent,
	output logic         gt
);

	trb_entry_t ent_q;

	// An empty cell counts as later than any event, so the incoming event
	// lands just after the last held entry whose stamp is not greater.
	assign gt  = !live || (ent_q.stamp > new_ent.stamp);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (op.ins && gt) begin
			ent_q <= left_gt ? left_ent : new_ent;
		end else if (op.shl) begin
			ent_q <= right_ent;
		end
	end

endmodule

>>> sv/timestamp_reorder_buffer_core.sv
// Timestamp reorder buffer: top level with control, timers and output stage.
// Depends on trb_pkg and trb_cell.
//
// The block takes key events, link-activity notices and time ticks as requests
// on the evt channel and emits key events on the res channel. While nothing is
// held, a local press is held only if link activity was seen fewer than
// active_ticks ticks ago, which also arms a countdown of window_ticks ticks;
// any other key event passes straight out. While events are held, every key
// event is held too, kept in ascending stamp order (equal stamps keep arrival
// order) by a row of DEPTH cells that insert in the cycle the request is
// taken. A remote event or expiry of the countdown drains the row from its
// head, one result per cycle while the res channel takes them, and the final
// result of the request carries last. When the row is full it is drained first
// and the new event then follows as the final result. The output register
// that feeds the res channel paces the draining, and a stalled consumer
// stretches it. The next request is taken once the current one has handed its
// last result to the output register, even if that result still waits there.
// Registers are written on cfg_we with cfg_index 0 for window_ticks and 1 for
// active_ticks; the user must write them only while the block is idle, which
// the block itself does not enforce. Timestamp wrap is not handled.
module timestamp_reorder_buffer_core
	import trb_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	// requests
	input  logic        evt_valid,
	output logic        evt_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  position,
	input  logic        pressed,
	input  logic        own_half,
	input  logic [31:0] stamp,
	// results
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_position,
	output logic        out_pressed,
	output logic        out_own_half,
	output logic [31:0] out_stamp,
	output logic        last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_PASS  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      window_q;
	logic [23:0]      active_q;
	logic [15:0]      countdown_q;
	logic             armed_q;
	logic [23:0]      age_q;
	logic             seen_q;
	logic             mark_last_q;
	logic             pass_q;
	trb_entry_t       pend_q;

	logic             res_valid_q;
	trb_entry_t       res_ent_q;
	logic             res_last_q;

	trb_entry_t       new_ent;
	trb_entry_t       ent [DEPTH];
	logic             gt  [DEPTH];
	trb_cell_op_t     op;
	logic             accept;
	logic             can_load;
	logic             active;
	logic             hold_first;

	assign new_ent = '{position: position, pressed: pressed, own_half: own_half, stamp: stamp};

	assign evt_ready = (state_q == ST_IDLE);
	assign accept    = evt_valid && evt_ready;
	// The output register can take a result when it is empty or being emptied.
	assign can_load  = !res_valid_q || res_ready;

	assign active     = seen_q && (age_q < active_q);
	assign hold_first = (count_q == '0) && own_half && pressed && active;

	always_comb begin
		op.ins = 1'b0;
		op.shl = 1'b0;
		if (accept && (action == ACT_KEY)) begin
			op.ins = (count_q == '0) ? hold_first : (count_q < CNT_FULL);
		end
		if ((state_q == ST_FLUSH) && can_load && (count_q != '0)) begin
			op.shl = 1'b1;
		end
	end

	// Row of cells: cell 0 is the head, holding the earliest stamp.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		trb_cell u_cell (
			.clk       (clk),
			.op        (op),
			.live      (CNT_W'(i) < count_q),
			.new_ent   (new_ent),
			.left_ent  ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i - 1]),
			.left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
			.right_ent (ent[(i == DEPTH - 1) ? i : i + 1]),
			.ent       (ent[i]),
			.gt        (gt[i])
		);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW) begin
				window_q <= cfg_data[15:0];
			end else begin
				active_q <= cfg_data;
			end
		end
	end

	// Control, timers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			countdown_q <= '0;
			armed_q     <= 1'b0;
			age_q       <= '0;
			seen_q      <= 1'b0;
			mark_last_q <= 1'b0;
			pass_q      <= 1'b0;
			pend_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_LINK: begin
								seen_q <= 1'b1;
								age_q  <= '0;
							end
							ACT_TICK: begin
								if (seen_q && (age_q != AGE_MAX)) begin
									age_q <= age_q + 24'd1;
								end
								if (armed_q) begin
									if (countdown_q <= 16'd1) begin
										countdown_q <= '0;
										armed_q     <= 1'b0;
										if (count_q != '0) begin
											state_q     <= ST_FLUSH;
											mark_last_q <= 1'b1;
											pass_q      <= 1'b0;
										end
									end else begin
										countdown_q <= countdown_q - 16'd1;
									end
								end
							end
							ACT_KEY: begin
								if (count_q == '0) begin
									if (hold_first) begin
										count_q     <= CNT_ONE;
										countdown_q <= window_q;
										armed_q     <= 1'b1;
									end else begin
										pend_q  <= new_ent;
										state_q <= ST_PASS;
									end
								end else if (count_q >= CNT_FULL) begin
									// Drain the full row first, then pass the new event.
									pend_q      <= new_ent;
									pass_q      <= 1'b1;
									mark_last_q <= 1'b0;
									state_q     <= ST_FLUSH;
									armed_q     <= 1'b0;
									countdown_q <= '0;
								end else begin
									count_q <= count_q + CNT_ONE;
									if (!own_half) begin
										state_q     <= ST_FLUSH;
										mark_last_q <= 1'b1;
										pass_q      <= 1'b0;
										armed_q     <= 1'b0;
										countdown_q <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FLUSH: begin
					if (count_q == '0) begin
						state_q <= pass_q ? ST_PASS : ST_IDLE;
					end else if (can_load) begin
						count_q <= count_q - CNT_ONE;
						if (count_q == CNT_ONE) begin
							state_q <= pass_q ? ST_PASS : ST_IDLE;
						end
					end
				end
				ST_PASS: begin
					if (can_load) begin
						state_q <= ST_IDLE;
						pass_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (op.shl || ((state_q == ST_PASS) && can_load)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op.shl) begin
			res_ent_q  <= ent[0];
			res_last_q <= mark_last_q && (count_q == CNT_ONE);
		end else if ((state_q == ST_PASS) && can_load) begin
			res_ent_q  <= pend_q;
			res_last_q <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_position = res_ent_q.position;
	assign out_pressed  = res_ent_q.pressed;
	assign out_own_half = res_ent_q.own_half;
	assign out_stamp    = res_ent_q.stamp;
	assign last         = res_last_q;

endmodule
